// ----- rtl/core/dcp_pkg.sv -----
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared widths, codes and payload types of the distance constraint pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned MASS_W      = 24;
  localparam int unsigned REST_W      = 31;
  localparam int unsigned STIFF_W     = 17;
  localparam int unsigned TOL_W       = 16;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned OUTCOME_W   = 2;

  localparam int unsigned AXES        = 3;
  localparam int unsigned PARTICLES   = 2;
  localparam int unsigned LANES       = 6;

  localparam int unsigned MAG_W       = 32;
  localparam int unsigned SQ_W        = 64;
  localparam int unsigned SUMSQ_W     = 66;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned ERR_W       = 34;
  localparam int unsigned WSUM_W      = 25;
  localparam int unsigned P1_W        = MASS_W + STIFF_W;
  localparam int unsigned P2_W        = ERR_W + MAG_W;
  localparam int unsigned DEN_W       = WSUM_W + DIST_W;
  localparam int unsigned CHUNKS      = 3;
  localparam int unsigned CHUNK_W     = P2_W / CHUNKS;
  localparam int unsigned PP_W        = P1_W + CHUNK_W;
  localparam int unsigned PROD_W      = P1_W + P2_W;
  localparam int unsigned STIFF_SHIFT = 16;
  localparam int unsigned NUM_W       = PROD_W - STIFF_SHIFT;
  localparam int unsigned QUO_W       = 34;

  localparam logic [QUO_W-1:0]   CORR_CLAMP  = QUO_W'(1) << 33;
  localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(65536);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(7);

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_CORRECTED  = 2'd0,
    OUTCOME_WITHIN_TOL = 2'd1,
    OUTCOME_DEGENERATE = 2'd2
  } outcome_e;

  typedef enum logic [0:0] {
    REG_STIFFNESS = 1'b0,
    REG_TOLERANCE = 1'b1
  } cfg_reg_e;

  typedef logic [LANES-1:0][POS_W-1:0]     pos6_t;
  typedef logic [PARTICLES-1:0][MASS_W-1:0] mass2_t;
  typedef logic [AXES-1:0][MAG_W-1:0]      mag3_t;
  typedef logic [LANES-1:0][NUM_W-1:0]     num_vec_t;
  typedef logic [LANES-1:0][QUO_W-1:0]     quo_vec_t;

  typedef struct packed {
    pos6_t             pos;
    mass2_t            mass;
    logic [REST_W-1:0] rest;
    mag3_t             mag;
    logic [AXES-1:0]   dneg;
  } sq_side_t;

  typedef struct packed {
    pos6_t           pos;
    logic [AXES-1:0] dneg;
    logic            cneg;
    outcome_e        outcome;
  } div_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/dcp_in_if.sv -----
// ----------------------------------------------------------------------------
// dcp_in_if
// Constraint input channel: two positions, inverse masses and rest length.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [dcp_pkg::POS_W-1:0]   first_x;
  logic signed [dcp_pkg::POS_W-1:0]   first_y;
  logic signed [dcp_pkg::POS_W-1:0]   first_z;
  logic signed [dcp_pkg::POS_W-1:0]   second_x;
  logic signed [dcp_pkg::POS_W-1:0]   second_y;
  logic signed [dcp_pkg::POS_W-1:0]   second_z;
  logic        [dcp_pkg::MASS_W-1:0]  first_inv_mass;
  logic        [dcp_pkg::MASS_W-1:0]  second_inv_mass;
  logic        [dcp_pkg::REST_W-1:0]  rest_length;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output first_inv_mass, second_inv_mass, rest_length,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  first_inv_mass, second_inv_mass, rest_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dcp_out_if.sv -----
// ----------------------------------------------------------------------------
// dcp_out_if
// Constraint result channel: corrected positions and outcome code.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dcp_pkg::POS_W-1:0]     new_first_x;
  logic signed [dcp_pkg::POS_W-1:0]     new_first_y;
  logic signed [dcp_pkg::POS_W-1:0]     new_first_z;
  logic signed [dcp_pkg::POS_W-1:0]     new_second_x;
  logic signed [dcp_pkg::POS_W-1:0]     new_second_y;
  logic signed [dcp_pkg::POS_W-1:0]     new_second_z;
  logic        [dcp_pkg::OUTCOME_W-1:0] outcome;

  modport source (
    output valid, new_first_x, new_first_y, new_first_z,
    output new_second_x, new_second_y, new_second_z, outcome,
    input  ready
  );

  modport sink (
    input  valid, new_first_x, new_first_y, new_first_z,
    input  new_second_x, new_second_y, new_second_z, outcome,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dcp_front.sv -----
// ----------------------------------------------------------------------------
// dcp_front
// Three stages: axis differences, squares, and the squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire dcp_pkg::pos6_t                    pos_i,
  input  wire dcp_pkg::mass2_t                   mass_i,
  input  wire logic [dcp_pkg::REST_W-1:0]        rest_i,
  output logic                                   valid_o,
  output dcp_pkg::sq_side_t                      side_o,
  output logic [dcp_pkg::SUMSQ_W-1:0]            sumsq_o
);

  logic                       a_v_q, b_v_q, c_v_q;
  dcp_pkg::sq_side_t          a_side_d, a_side_q, b_side_q, c_side_q;
  logic [dcp_pkg::SQ_W-1:0]   b_sq_d [dcp_pkg::AXES];
  logic [dcp_pkg::SQ_W-1:0]   b_sq_q [dcp_pkg::AXES];
  logic [dcp_pkg::SUMSQ_W-1:0] c_sum_d, c_sum_q;

  // differences and magnitudes
  always_comb begin
    logic [dcp_pkg::POS_W:0] diff;
    a_side_d      = '0;
    a_side_d.pos  = pos_i;
    a_side_d.mass = mass_i;
    a_side_d.rest = rest_i;
    for (int k = 0; k < dcp_pkg::AXES; k++) begin
      diff = {pos_i[k][dcp_pkg::POS_W-1], pos_i[k]}
           - {pos_i[k+dcp_pkg::AXES][dcp_pkg::POS_W-1], pos_i[k+dcp_pkg::AXES]};
      a_side_d.dneg[k] = diff[dcp_pkg::POS_W];
      a_side_d.mag[k]  = diff[dcp_pkg::POS_W] ? dcp_pkg::MAG_W'(~diff + 1'b1)
                                              : dcp_pkg::MAG_W'(diff);
    end
  end

  always_comb begin
    for (int k = 0; k < dcp_pkg::AXES; k++) begin
      b_sq_d[k] = dcp_pkg::SQ_W'(a_side_q.mag[k]) * dcp_pkg::SQ_W'(a_side_q.mag[k]);
    end
  end

  assign c_sum_d = dcp_pkg::SUMSQ_W'(b_sq_q[0]) + dcp_pkg::SUMSQ_W'(b_sq_q[1])
                 + dcp_pkg::SUMSQ_W'(b_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= a_side_d;
      b_side_q <= a_side_q;
      b_sq_q   <= b_sq_d;
      c_side_q <= b_side_q;
      c_sum_q  <= c_sum_d;
    end
  end

  assign valid_o = c_v_q;
  assign side_o  = c_side_q;
  assign sumsq_o = c_sum_q;

endmodule

`default_nettype wire

// ----- rtl/core/dcp_sqrt.sv -----
// ----------------------------------------------------------------------------
// dcp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [dcp_pkg::SUMSQ_W-1:0]       sumsq_i,
  input  wire dcp_pkg::sq_side_t                 side_i,
  output logic                                   valid_o,
  output logic [dcp_pkg::DIST_W-1:0]             dist_o,
  output dcp_pkg::sq_side_t                      side_o
);

  localparam int unsigned Steps  = dcp_pkg::DIST_W;
  localparam int unsigned TrialW = dcp_pkg::SUMSQ_W + 2;

  logic                          v_q    [Steps];
  logic [dcp_pkg::SUMSQ_W-1:0]   rem_q  [Steps];
  logic [dcp_pkg::DIST_W-1:0]    root_q [Steps];
  dcp_pkg::sq_side_t             side_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - j;

    logic                        v_in;
    logic [dcp_pkg::SUMSQ_W-1:0] rem_in;
    logic [dcp_pkg::DIST_W-1:0]  root_in;
    dcp_pkg::sq_side_t           side_in;
    logic [TrialW-1:0]           trial;
    logic                        take;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = sumsq_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    // (2r + 2^b) * 2^b against the remaining square
    assign trial = (TrialW'(root_in) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign take  = (trial <= TrialW'(rem_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_in - trial[dcp_pkg::SUMSQ_W-1:0] : rem_in;
        root_q[j] <= root_in | (dcp_pkg::DIST_W'(take) << Bit);
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign dist_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

`default_nettype wire

// ----- rtl/core/dcp_scale.sv -----
// ----------------------------------------------------------------------------
// dcp_scale
// Constraint error, outcome, and the correction numerators and denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_scale (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [dcp_pkg::DIST_W-1:0]        dist_i,
  input  wire dcp_pkg::sq_side_t                 side_i,
  input  wire logic [dcp_pkg::STIFF_W-1:0]       stiffness_i,
  input  wire logic [dcp_pkg::TOL_W-1:0]         tolerance_i,
  output logic                                   valid_o,
  output dcp_pkg::num_vec_t                      num_o,
  output logic [dcp_pkg::DEN_W-1:0]              den_o,
  output dcp_pkg::div_side_t                     side_o
);

  localparam int unsigned AX = dcp_pkg::AXES;

  // stage 1: error and outcome
  logic                        m1_v_q;
  logic [dcp_pkg::ERR_W-1:0]   m1_cm_d, m1_cm_q;
  logic                        m1_cneg_d, m1_cneg_q;
  logic [dcp_pkg::WSUM_W-1:0]  m1_wsum_d, m1_wsum_q;
  logic [dcp_pkg::DIST_W-1:0]  m1_dist_q;
  dcp_pkg::sq_side_t           m1_side_q;
  dcp_pkg::outcome_e           m1_out_d, m1_out_q;

  // stage 2: narrow products
  logic                        m2_v_q;
  logic [dcp_pkg::P1_W-1:0]    m2_p1_q [dcp_pkg::PARTICLES];
  logic [dcp_pkg::P2_W-1:0]    m2_p2_q [AX];
  logic [dcp_pkg::DEN_W-1:0]   m2_den_q;
  dcp_pkg::div_side_t          m2_side_d, m2_side_q;

  // stage 3: partial products
  logic                        m3_v_q;
  logic [dcp_pkg::PP_W-1:0]    m3_pp_d [dcp_pkg::LANES][dcp_pkg::CHUNKS];
  logic [dcp_pkg::PP_W-1:0]    m3_pp_q [dcp_pkg::LANES][dcp_pkg::CHUNKS];
  logic [dcp_pkg::DEN_W-1:0]   m3_den_q;
  dcp_pkg::div_side_t          m3_side_q;

  // stage 4: numerators
  logic                        m4_v_q;
  dcp_pkg::num_vec_t           m4_num_d, m4_num_q;
  logic [dcp_pkg::DEN_W-1:0]   m4_den_q;
  dcp_pkg::div_side_t          m4_side_q;

  always_comb begin
    logic [dcp_pkg::ERR_W-1:0] c;
    c         = {1'b0, dist_i} - dcp_pkg::ERR_W'(side_i.rest);
    m1_cneg_d = c[dcp_pkg::ERR_W-1];
    m1_cm_d   = m1_cneg_d ? (~c + 1'b1) : c;
    m1_wsum_d = dcp_pkg::WSUM_W'(side_i.mass[0]) + dcp_pkg::WSUM_W'(side_i.mass[1]);
    // tolerance test wins over the degenerate test
    if (m1_cm_d < dcp_pkg::ERR_W'(tolerance_i)) begin
      m1_out_d = dcp_pkg::OUTCOME_WITHIN_TOL;
    end else if (dist_i == '0 || m1_wsum_d == '0) begin
      m1_out_d = dcp_pkg::OUTCOME_DEGENERATE;
    end else begin
      m1_out_d = dcp_pkg::OUTCOME_CORRECTED;
    end
  end

  always_comb begin
    m2_side_d.pos     = m1_side_q.pos;
    m2_side_d.dneg    = m1_side_q.dneg;
    m2_side_d.cneg    = m1_cneg_q;
    m2_side_d.outcome = m1_out_q;
  end

  always_comb begin
    int l;
    for (int i = 0; i < dcp_pkg::PARTICLES; i++) begin
      for (int k = 0; k < AX; k++) begin
        l = i * AX + k;
        for (int j = 0; j < dcp_pkg::CHUNKS; j++) begin
          m3_pp_d[l][j] = dcp_pkg::PP_W'(m2_p1_q[i])
                        * dcp_pkg::PP_W'(m2_p2_q[k][j*dcp_pkg::CHUNK_W +: dcp_pkg::CHUNK_W]);
        end
      end
    end
  end

  always_comb begin
    logic [dcp_pkg::PROD_W-1:0] prod;
    for (int l = 0; l < dcp_pkg::LANES; l++) begin
      prod = dcp_pkg::PROD_W'(m3_pp_q[l][0])
           + (dcp_pkg::PROD_W'(m3_pp_q[l][1]) << dcp_pkg::CHUNK_W)
           + (dcp_pkg::PROD_W'(m3_pp_q[l][2]) << (2 * dcp_pkg::CHUNK_W));
      // the stiffness scale of one is taken out as a right shift of the product
      m4_num_d[l] = prod[dcp_pkg::PROD_W-1:dcp_pkg::STIFF_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
    end else if (en_i) begin
      m1_v_q <= valid_i;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_cm_q   <= m1_cm_d;
      m1_cneg_q <= m1_cneg_d;
      m1_wsum_q <= m1_wsum_d;
      m1_dist_q <= dist_i;
      m1_side_q <= side_i;
      m1_out_q  <= m1_out_d;

      for (int i = 0; i < dcp_pkg::PARTICLES; i++) begin
        m2_p1_q[i] <= dcp_pkg::P1_W'(m1_side_q.mass[i]) * dcp_pkg::P1_W'(stiffness_i);
      end
      for (int k = 0; k < AX; k++) begin
        m2_p2_q[k] <= dcp_pkg::P2_W'(m1_cm_q) * dcp_pkg::P2_W'(m1_side_q.mag[k]);
      end
      m2_den_q  <= dcp_pkg::DEN_W'(m1_wsum_q) * dcp_pkg::DEN_W'(m1_dist_q);
      m2_side_q <= m2_side_d;

      m3_pp_q   <= m3_pp_d;
      m3_den_q  <= m2_den_q;
      m3_side_q <= m2_side_q;

      m4_num_q  <= m4_num_d;
      m4_den_q  <= m3_den_q;
      m4_side_q <= m3_side_q;
    end
  end

  assign valid_o = m4_v_q;
  assign num_o   = m4_num_q;
  assign den_o   = m4_den_q;
  assign side_o  = m4_side_q;

endmodule

`default_nettype wire

// ----- rtl/core/dcp_div.sv -----
// ----------------------------------------------------------------------------
// dcp_div
// Six-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage, with an overflow flag for quotients too wide for the stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire dcp_pkg::num_vec_t                 num_i,
  input  wire logic [dcp_pkg::DEN_W-1:0]         den_i,
  input  wire dcp_pkg::div_side_t                side_i,
  output logic                                   valid_o,
  output dcp_pkg::quo_vec_t                      quo_o,
  output logic [dcp_pkg::LANES-1:0]              ovf_o,
  output logic [dcp_pkg::DEN_W-1:0]              den_o,
  output dcp_pkg::div_side_t                     side_o
);

  localparam int unsigned Steps = dcp_pkg::QUO_W;
  localparam int unsigned NW    = dcp_pkg::NUM_W;

  logic                          v_q    [Steps];
  dcp_pkg::num_vec_t             rem_q  [Steps];
  dcp_pkg::quo_vec_t             quo_q  [Steps];
  logic [dcp_pkg::LANES-1:0]     ovf_q  [Steps];
  logic [dcp_pkg::DEN_W-1:0]     den_q  [Steps];
  dcp_pkg::div_side_t            side_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - j;

    logic                      v_in;
    dcp_pkg::num_vec_t         rem_in, rem_d;
    dcp_pkg::quo_vec_t         quo_in, quo_d;
    logic [dcp_pkg::LANES-1:0] ovf_in;
    logic [dcp_pkg::DEN_W-1:0] den_in;
    dcp_pkg::div_side_t        side_in;
    logic [NW-1:0]             dsh;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      // quotient would need more bits than the stages give
      always_comb begin
        for (int l = 0; l < dcp_pkg::LANES; l++) begin
          ovf_in[l] = ({1'b0, num_i[l]} >= {den_i, dcp_pkg::QUO_W'(0)});
        end
      end
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign ovf_in  = ovf_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign dsh = NW'(den_in) << Bit;

    always_comb begin
      logic take;
      for (int l = 0; l < dcp_pkg::LANES; l++) begin
        take     = (rem_in[l] >= dsh);
        rem_d[l] = take ? rem_in[l] - dsh : rem_in[l];
        quo_d[l] = quo_in[l] | (dcp_pkg::QUO_W'(take) << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        ovf_q[j]  <= ovf_in;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign ovf_o   = ovf_q[Steps-1];
  assign den_o   = den_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

`default_nettype wire

// ----- rtl/core/distance_constraint_projection.sv -----
// ----------------------------------------------------------------------------
// distance_constraint_projection
// Distance constraint projection for two particles, fully pipelined.
// ----------------------------------------------------------------------------
// stages in order: front, square root, scaling, divider, output register
// throughput: one constraint per cycle; the whole pipeline holds while a
//   result waits at the output register
// reset: clears all valid bits, stiffness returns to one, tolerance to 7
`default_nettype none

module distance_constraint_projection (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  dcp_in_if.sink                              in_i,
  dcp_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [dcp_pkg::CFG_W-1:0]      cfg_data_i
);

  logic                           en;
  logic [dcp_pkg::STIFF_W-1:0]    stiff_q;
  logic [dcp_pkg::TOL_W-1:0]      tol_q;

  dcp_pkg::pos6_t                 in_pos;
  dcp_pkg::mass2_t                in_mass;

  logic                           fr_valid;
  dcp_pkg::sq_side_t              fr_side;
  logic [dcp_pkg::SUMSQ_W-1:0]    fr_sumsq;

  logic                           sq_valid;
  logic [dcp_pkg::DIST_W-1:0]     sq_dist;
  dcp_pkg::sq_side_t              sq_side;

  logic                           sc_valid;
  dcp_pkg::num_vec_t              sc_num;
  logic [dcp_pkg::DEN_W-1:0]      sc_den;
  dcp_pkg::div_side_t             sc_side;

  logic                           div_valid;
  dcp_pkg::quo_vec_t              div_quo;
  logic [dcp_pkg::LANES-1:0]      div_ovf;
  logic [dcp_pkg::DEN_W-1:0]      div_den;
  dcp_pkg::div_side_t             div_side;

  logic                           out_valid_q;
  dcp_pkg::pos6_t                 out_pos_d, out_pos_q;
  dcp_pkg::outcome_e              out_outcome_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign in_pos  = {in_i.second_z, in_i.second_y, in_i.second_x,
                    in_i.first_z, in_i.first_y, in_i.first_x};
  assign in_mass = {in_i.second_inv_mass, in_i.first_inv_mass};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= dcp_pkg::STIFF_RESET;
      tol_q   <= dcp_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (dcp_pkg::cfg_reg_e'(cfg_idx_i))
        dcp_pkg::REG_STIFFNESS: begin
          stiff_q <= cfg_data_i[dcp_pkg::STIFF_W-1:0];
        end
        dcp_pkg::REG_TOLERANCE: begin
          tol_q <= cfg_data_i[dcp_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  dcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .pos_i   (in_pos),
    .mass_i  (in_mass),
    .rest_i  (in_i.rest_length),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .sumsq_o (fr_sumsq)
  );

  dcp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .sumsq_i (fr_sumsq),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .dist_o  (sq_dist),
    .side_o  (sq_side)
  );

  dcp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (sq_valid),
    .dist_i      (sq_dist),
    .side_i      (sq_side),
    .stiffness_i (stiff_q),
    .tolerance_i (tol_q),
    .valid_o     (sc_valid),
    .num_o       (sc_num),
    .den_o       (sc_den),
    .side_o      (sc_side)
  );

  dcp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sc_valid),
    .num_i   (sc_num),
    .den_i   (sc_den),
    .side_i  (sc_side),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf),
    .den_o   (div_den),
    .side_o  (div_side)
  );

  // clamp, apply sign, saturate; items not marked corrected pass unchanged
  always_comb begin
    logic [dcp_pkg::QUO_W-1:0] m;
    logic [dcp_pkg::QUO_W+1:0] delta;
    logic [dcp_pkg::QUO_W+1:0] sum;
    logic                      neg;
    int                        l;
    for (int i = 0; i < dcp_pkg::PARTICLES; i++) begin
      for (int k = 0; k < dcp_pkg::AXES; k++) begin
        l = i * dcp_pkg::AXES + k;
        m = (div_ovf[l] || div_quo[l] > dcp_pkg::CORR_CLAMP) ? dcp_pkg::CORR_CLAMP
                                                             : div_quo[l];
        // when too long, first particle moves against the difference, second along it; reversed when too short
        neg   = (div_side.cneg != div_side.dneg[k]) != (i == 0);
        delta = neg ? (~{2'b00, m} + 1'b1) : {2'b00, m};
        sum   = {{(dcp_pkg::QUO_W+2-dcp_pkg::POS_W){div_side.pos[l][dcp_pkg::POS_W-1]}},
                 div_side.pos[l]} + delta;
        if (div_side.outcome != dcp_pkg::OUTCOME_CORRECTED) begin
          out_pos_d[l] = div_side.pos[l];
        end else if (sum[dcp_pkg::QUO_W+1:dcp_pkg::POS_W-1] == '0 ||
                     sum[dcp_pkg::QUO_W+1:dcp_pkg::POS_W-1] == '1) begin
          out_pos_d[l] = sum[dcp_pkg::POS_W-1:0];
        end else begin
          out_pos_d[l] = sum[dcp_pkg::QUO_W+1] ? {1'b1, {(dcp_pkg::POS_W-1){1'b0}}}
                                               : {1'b0, {(dcp_pkg::POS_W-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_q     <= out_pos_d;
      out_outcome_q <= div_side.outcome;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.new_first_x  = out_pos_q[0];
  assign out_o.new_first_y  = out_pos_q[1];
  assign out_o.new_first_z  = out_pos_q[2];
  assign out_o.new_second_x = out_pos_q[3];
  assign out_o.new_second_y = out_pos_q[4];
  assign out_o.new_second_z = out_pos_q[5];
  assign out_o.outcome      = out_outcome_q;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while a result is held");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && div_side.outcome == dcp_pkg::OUTCOME_CORRECTED) |-> div_den != '0)
    else $error("corrected item with zero divisor");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(div_valid))
    else $error("result appeared without a divider result");

endmodule

`default_nettype wire

// ----- verif/tb_distance_constraint_projection.sv -----
// ----------------------------------------------------------------------------
// tb_distance_constraint_projection
// Self-checking bench for the distance constraint pipeline. Streams directed
// and random constraints across several stiffness and tolerance settings,
// with random source gaps and sink stalls in all but one random phase, and
// checks every result against a bit-exact projection model or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_distance_constraint_projection;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned RAND_ITEMS  = 500;

  typedef struct {
    logic signed [dcp_pkg::POS_W-1:0] pos [dcp_pkg::LANES];
    logic [dcp_pkg::MASS_W-1:0]       w [dcp_pkg::PARTICLES];
    logic [dcp_pkg::REST_W-1:0]       rest;
  } cons_t;

  typedef struct {
    logic [dcp_pkg::POS_W-1:0]     pos [dcp_pkg::LANES];
    logic [dcp_pkg::OUTCOME_W-1:0] outcome;
  } proj_t;

  typedef struct {
    cons_t                         c;
    bit                            typed;
    logic [dcp_pkg::OUTCOME_W-1:0] outcome;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [dcp_pkg::CFG_W-1:0] cfg_data_i = '0;

  dcp_in_if  in_if ();
  dcp_out_if out_if ();

  distance_constraint_projection dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [dcp_pkg::STIFF_W-1:0] stiff_cfg = dcp_pkg::STIFF_RESET;
  logic [dcp_pkg::TOL_W-1:0]   tol_cfg   = dcp_pkg::TOL_RESET;
  proj_t              pending_proj [$];
  row_t               rows [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  int unsigned        stall_left = 0;
  bit                 calm = 1'b0;

  function automatic logic [dcp_pkg::DIST_W-1:0] isqrt(logic [dcp_pkg::SUMSQ_W-1:0] s);
    logic [71:0] r;
    logic [71:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (72'd1 << b);
      if (c * c <= 72'(s)) r = c;
    end
    return r[dcp_pkg::DIST_W-1:0];
  endfunction

  function automatic logic [dcp_pkg::SUMSQ_W-1:0] sum_sq(cons_t c);
    logic signed [32:0]          d;
    logic [dcp_pkg::SUMSQ_W-1:0] s;
    s = '0;
    for (int k = 0; k < dcp_pkg::AXES; k++) begin
      d = $signed({c.pos[k][31], c.pos[k]}) - $signed({c.pos[k+3][31], c.pos[k+3]});
      if (d < 0) d = -d;
      s += dcp_pkg::SUMSQ_W'(d[31:0]) * dcp_pkg::SUMSQ_W'(d[31:0]);
    end
    return s;
  endfunction

  function automatic proj_t project(cons_t c);
    proj_t                      r;
    logic signed [32:0]         d [dcp_pkg::AXES];
    logic [dcp_pkg::MAG_W-1:0]  mag [dcp_pkg::AXES];
    logic [dcp_pkg::DIST_W-1:0] span;
    logic signed [34:0]         err;
    logic [dcp_pkg::ERR_W-1:0]  cm;
    logic [dcp_pkg::WSUM_W-1:0] wsum;
    logic [127:0]               num;
    logic [127:0]               den;
    logic [127:0]               q;
    logic [33:0]                m;
    logic signed [35:0]         sum;
    bit                         neg;
    for (int k = 0; k < dcp_pkg::AXES; k++) begin
      d[k] = $signed({c.pos[k][31], c.pos[k]}) - $signed({c.pos[k+3][31], c.pos[k+3]});
      mag[k] = (d[k] < 0) ? dcp_pkg::MAG_W'(-d[k]) : dcp_pkg::MAG_W'(d[k]);
    end
    span = isqrt(sum_sq(c));
    err = $signed({2'b00, span}) - $signed({4'b0000, c.rest});
    cm = (err < 0) ? dcp_pkg::ERR_W'(-err) : dcp_pkg::ERR_W'(err);
    wsum = dcp_pkg::WSUM_W'(c.w[0]) + dcp_pkg::WSUM_W'(c.w[1]);
    for (int k = 0; k < dcp_pkg::LANES; k++) r.pos[k] = c.pos[k];
    if (cm < dcp_pkg::ERR_W'(tol_cfg)) begin
      r.outcome = dcp_pkg::OUTCOME_WITHIN_TOL;
      return r;
    end
    if (span == 0 || wsum == 0) begin
      r.outcome = dcp_pkg::OUTCOME_DEGENERATE;
      return r;
    end
    den = 128'(wsum) * 128'(span) * 128'(65536);
    for (int i = 0; i < dcp_pkg::PARTICLES; i++) begin
      for (int k = 0; k < dcp_pkg::AXES; k++) begin
        num = 128'(cm) * 128'(c.w[i]) * 128'(stiff_cfg) * 128'(mag[k]);
        q = num / den;
        m = (q > 128'(dcp_pkg::CORR_CLAMP)) ? dcp_pkg::CORR_CLAMP : q[33:0];
        neg = ((err < 0) != (d[k] < 0)) != (i == 0);
        sum = $signed({{4{c.pos[i*3+k][31]}}, c.pos[i*3+k]})
              + (neg ? -$signed({2'b00, m}) : $signed({2'b00, m}));
        if (sum > 36'sd2147483647) r.pos[i*3+k] = 32'h7fffffff;
        else if (sum < -36'sd2147483648) r.pos[i*3+k] = 32'h80000000;
        else r.pos[i*3+k] = sum[31:0];
      end
    end
    r.outcome = dcp_pkg::OUTCOME_CORRECTED;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 12) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cons_t make_cons(int ax, int ay, int az, int bx, int by, int bz,
                                      int unsigned w0, int unsigned w1, int unsigned rest);
    cons_t c;
    c.pos[0] = ax; c.pos[1] = ay; c.pos[2] = az;
    c.pos[3] = bx; c.pos[4] = by; c.pos[5] = bz;
    c.w[0] = w0[dcp_pkg::MASS_W-1:0];
    c.w[1] = w1[dcp_pkg::MASS_W-1:0];
    c.rest = rest[dcp_pkg::REST_W-1:0];
    return c;
  endfunction

  function automatic void add_row(cons_t c, bit typed, logic [dcp_pkg::OUTCOME_W-1:0] oc);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.outcome = oc;
    rows.push_back(r);
  endfunction

  function automatic cons_t rand_cons();
    cons_t                      c;
    int unsigned                mode;
    int signed                  off;
    logic [dcp_pkg::DIST_W-1:0] span;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < dcp_pkg::AXES; k++) begin
      if (mode == 0) begin
        c.pos[k] = $urandom();
        c.pos[k+3] = $urandom();
      end else begin
        c.pos[k] = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        off = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
        c.pos[k+3] = (mode == 1) ? c.pos[k] : c.pos[k] + off;
      end
    end
    for (int i = 0; i < dcp_pkg::PARTICLES; i++) begin
      case ($urandom_range(0, 9))
        0: c.w[i] = '0;
        1: c.w[i] = '1;
        2, 3: c.w[i] = dcp_pkg::MASS_W'($urandom());
        default: c.w[i] = dcp_pkg::MASS_W'($urandom_range(1, 24'h0fffff));
      endcase
    end
    if (mode == 2) c.w = '{default: '0};
    span = isqrt(sum_sq(c));
    case ($urandom_range(0, 4))
      0: c.rest = dcp_pkg::REST_W'($urandom());
      1: c.rest = dcp_pkg::REST_W'(span) + dcp_pkg::REST_W'($urandom_range(0, 20))
                  - dcp_pkg::REST_W'(10);
      default: c.rest = dcp_pkg::REST_W'($urandom_range(0, 32'h003fffff));
    endcase
    return c;
  endfunction

  task automatic write_reg(dcp_pkg::cfg_reg_e idx, logic [dcp_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == dcp_pkg::REG_STIFFNESS) stiff_cfg = val[dcp_pkg::STIFF_W-1:0];
    else tol_cfg = val[dcp_pkg::TOL_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // one transfer on the input channel; gap applied afterwards
  task automatic send(cons_t c, bit typed, logic [dcp_pkg::OUTCOME_W-1:0] oc);
    int unsigned gap;
    proj_t       e;
    in_if.first_x = c.pos[0];
    in_if.first_y = c.pos[1];
    in_if.first_z = c.pos[2];
    in_if.second_x = c.pos[3];
    in_if.second_y = c.pos[4];
    in_if.second_z = c.pos[5];
    in_if.first_inv_mass = c.w[0];
    in_if.second_inv_mass = c.w[1];
    in_if.rest_length = c.rest;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (typed) begin
      for (int k = 0; k < dcp_pkg::LANES; k++) e.pos[k] = c.pos[k];
      e.outcome = oc;
    end else begin
      e = project(c);
    end
    pending_proj.push_back(e);
    gap = calm ? 0 : idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.first_x = '0;
    in_if.first_y = '0;
    in_if.first_z = '0;
    in_if.second_x = '0;
    in_if.second_y = '0;
    in_if.second_z = '0;
    in_if.first_inv_mass = '0;
    in_if.second_inv_mass = '0;
    in_if.rest_length = '0;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= idle_len();
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    proj_t                     e;
    logic [dcp_pkg::POS_W-1:0] got [dcp_pkg::LANES];
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.new_first_x, out_if.new_first_y, out_if.new_first_z,
              out_if.new_second_x, out_if.new_second_y, out_if.new_second_z};
      if (pending_proj.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        e = pending_proj.pop_front();
        for (int k = 0; k < dcp_pkg::LANES; k++) begin
          if (got[k] !== e.pos[k]) begin
            $display("%0t: lane %0d expected %h actual %h", $time, k, e.pos[k], got[k]);
            errors++;
          end
        end
        if (out_if.outcome !== e.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, e.outcome,
                   out_if.outcome);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [dcp_pkg::STIFF_W-1:0] stiff_set [5];
    logic [dcp_pkg::TOL_W-1:0]   tol_set [5];

    // directed rows at reset settings (stiffness one, tolerance 7)
    add_row(make_cons(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, dcp_pkg::OUTCOME_WITHIN_TOL);
    add_row(make_cons(5, 5, 5, 5, 5, 5, 65536, 65536, 1000), 1,
            dcp_pkg::OUTCOME_DEGENERATE);
    add_row(make_cons(655360, 0, 0, 0, 0, 0, 0, 0, 0), 1, dcp_pkg::OUTCOME_DEGENERATE);
    add_row(make_cons(65536, 0, 0, 0, 0, 0, 65536, 65536, 65536), 1,
            dcp_pkg::OUTCOME_WITHIN_TOL);
    add_row(make_cons(65536, 0, 0, 0, 0, 0, 65536, 65536, 65542), 1,
            dcp_pkg::OUTCOME_WITHIN_TOL);
    add_row(make_cons(65536, 0, 0, 0, 0, 0, 65536, 65536, 65543), 0, '0);
    add_row(make_cons(65536, 0, 0, 0, 0, 0, 65536, 65536, 65529), 0, '0);
    add_row(make_cons(7, 7, 7, 7, 7, 7, 1, 1, 32'h7fffffff), 1,
            dcp_pkg::OUTCOME_DEGENERATE);
    add_row(make_cons(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                      32'h80000000, 32'h80000000, 24'hffffff, 24'hffffff, 0), 0, '0);
    add_row(make_cons(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff, 24'hffffff, 0, 32'h7fffffff), 0, '0);
    add_row(make_cons(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 1, 24'hffffff, 0), 0, '0);
    add_row(make_cons(1, 0, 0, 0, 0, 0, 24'hffffff, 24'hffffff, 32'h7fffffff), 0, '0);
    add_row(make_cons(-65536, 131072, -196608, 65536, -131072, 196608, 0, 65536,
                      65536), 0, '0);
    add_row(make_cons(100000, -200000, 300000, -50000, 60000, -70000, 65536, 0,
                      2000000), 0, '0);
    add_row(make_cons(1, 1, 1, 0, 0, 0, 24'hffffff, 24'hffffff, 1), 1,
            dcp_pkg::OUTCOME_WITHIN_TOL);

    stiff_set = '{dcp_pkg::STIFF_RESET, 17'd0, 17'h1ffff, 17'd32768, 17'd65536};
    tol_set   = '{dcp_pkg::TOL_RESET, 16'd0, 16'hffff, 16'd1, 16'd300};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    calm = 1'b1;
    foreach (rows[r]) send(rows[r].c, rows[r].typed, rows[r].outcome);
    in_if.valid = 1'b0;
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(dcp_pkg::REG_STIFFNESS,
                (ph == 4) ? dcp_pkg::CFG_W'($urandom_range(0, 17'h1ffff))
                          : dcp_pkg::CFG_W'(stiff_set[ph]));
      write_reg(dcp_pkg::REG_TOLERANCE,
                (ph == 4) ? dcp_pkg::CFG_W'($urandom_range(0, 16'hffff))
                          : dcp_pkg::CFG_W'(tol_set[ph]));
      calm = (ph == 2);
      for (int n = 0; n < RAND_ITEMS / 5; n++) send(rand_cons(), 0, '0);
      in_if.valid = 1'b0;
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
